### rtl/swec_pkg.sv
// ----------------------------------------------------------------------------
// swec_pkg
// Shared types and constants of the sliding window event counter.
// ----------------------------------------------------------------------------
package swec_pkg;

   localparam int CNT_W     = 48;   // bucket and total width
   localparam int EVT_W     = 32;   // event count width
   localparam int TIME_W    = 63;   // timestamp width
   localparam int TICKS_W   = 32;   // window length width
   localparam int WCNT_W    = 5;    // window count register width
   localparam int ALU_W     = 64;   // shared adder width
   localparam int CMD_W     = 2;
   localparam int STEP_W    = 6;    // divider step counter
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CMD_W-1:0] CMD_RECORD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESET   = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_COUNT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_TICKS = 1'b1;

   localparam logic [WCNT_W-1:0]  WINDOW_COUNT_RST = 5'd16;
   localparam logic [TICKS_W-1:0] WINDOW_TICKS_RST = 32'd10000000;

   localparam logic [STEP_W-1:0] DIV_LAST_STEP = 6'(TIME_W - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_DIV,
      ST_START,
      ST_GAP,
      ST_DROP_RD,
      ST_DROP,
      ST_APPEND,
      ST_TRIM,
      ST_REC_RD,
      ST_REC_BKT,
      ST_REC_TOT,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type         op;
      logic [ALU_W-1:0]   a;
      logic [ALU_W-1:0]   b;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0]   result;
      logic               flag;   // carry on add, borrow on subtract
   } alu_rsp_type;

   typedef struct packed {
      logic [WCNT_W-1:0]  window_count;
      logic [TICKS_W-1:0] window_ticks;
   } cfg_type;

   typedef struct packed {
      logic               done;
      logic [CNT_W-1:0]   total;
   } status_type;

endpackage

### rtl/swec_alu.sv
// ----------------------------------------------------------------------------
// swec_alu
// Shared 64-bit adder/subtractor used for the timestamp, division and count arithmetic of an item.
// ----------------------------------------------------------------------------
module swec_alu (
   input  swec_pkg::alu_req_type alu_req,
   output swec_pkg::alu_rsp_type alu_rsp
);

   logic [swec_pkg::ALU_W:0] sum;

   always_comb begin
      if (alu_req.op == swec_pkg::ALU_SUB) begin
         sum = {1'b0, alu_req.a} + {1'b0, ~alu_req.b} + {{swec_pkg::ALU_W{1'b0}}, 1'b1};
      end else begin
         sum = {1'b0, alu_req.a} + {1'b0, alu_req.b};
      end
      alu_rsp.result = sum[swec_pkg::ALU_W-1:0];
      // carry out of a subtract is the inverse of borrow
      alu_rsp.flag = (alu_req.op == swec_pkg::ALU_SUB) ? ~sum[swec_pkg::ALU_W]
                                                       : sum[swec_pkg::ALU_W];
   end

endmodule

### rtl/swec_seq.sv
// ----------------------------------------------------------------------------
// swec_seq
// Sequencer, window state and bucket ring memory; drives the shared adder.
// ----------------------------------------------------------------------------
module swec_seq #(
   parameter int MAX_WINDOWS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  swec_pkg::cfg_type                   cfg,
   input  logic                                req_valid,
   input  logic [swec_pkg::CMD_W-1:0]          req_cmd,
   input  logic [swec_pkg::EVT_W-1:0]          req_event_count,
   input  logic [swec_pkg::TIME_W-1:0]         req_now,
   output logic                                req_ready,
   input  logic                                load_ok,
   output swec_pkg::status_type                status,
   output swec_pkg::alu_req_type               alu_req,
   input  swec_pkg::alu_rsp_type               alu_rsp
);

   localparam int SW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CW = $clog2(MAX_WINDOWS + 1);

   localparam int CNT_W  = swec_pkg::CNT_W;
   localparam int TIME_W = swec_pkg::TIME_W;
   localparam int ALU_W  = swec_pkg::ALU_W;

   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] s, input logic [CW-1:0] n);
      logic [CW:0] sum;
      sum = (CW+1)'(s) + (CW+1)'(n);
      if (sum >= (CW+1)'(MAX_WINDOWS)) begin
         sum = sum - (CW+1)'(MAX_WINDOWS);
      end
      return SW'(sum);
   endfunction

   swec_pkg::state_type state_ff, state_in;

   logic [swec_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [swec_pkg::EVT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]            latest_ff, latest_in;
   logic [TIME_W-1:0]            div_ff, div_in;     // timestamp, quotient, then start
   logic [swec_pkg::TICKS_W-1:0] rem_ff, rem_in;
   logic [swec_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [TIME_W-1:0]            first_ff, first_in;
   logic [CNT_W-1:0]             total_ff, total_in;
   logic [SW-1:0]                oldest_ff, oldest_in;
   logic [CW-1:0]                in_use_ff, in_use_in;
   logic [CW-1:0]                drop_ff, drop_in;
   logic [CW-1:0]                target_ff, target_in;
   logic                         trim_ff, trim_in;
   logic [CNT_W-1:0]             rd_data_ff;

   logic [CNT_W-1:0]             mem [MAX_WINDOWS];
   logic                         mem_we;
   logic [SW-1:0]                mem_waddr;
   logic [CNT_W-1:0]             mem_wdata;
   logic [SW-1:0]                rd_addr;

   logic [CW-1:0]                wc_eff;
   logic [swec_pkg::TICKS_W-1:0] ticks_eff;
   logic [SW-1:0]                newest_slot;
   logic [SW-1:0]                oldest_inc;
   logic [swec_pkg::TICKS_W:0]   rem_shift;
   logic [ALU_W-1:0]             res;

   always_comb begin
      if (cfg.window_count == '0) begin
         wc_eff = CW'(1);
      end else if (32'(cfg.window_count) > 32'(MAX_WINDOWS)) begin
         wc_eff = CW'(MAX_WINDOWS);
      end else begin
         wc_eff = CW'(cfg.window_count);
      end
      ticks_eff = (cfg.window_ticks == '0) ? swec_pkg::TICKS_W'(1) : cfg.window_ticks;
   end

   assign newest_slot = slot_add(oldest_ff, in_use_ff - CW'(1));
   assign oldest_inc  = slot_add(oldest_ff, CW'(1));
   assign rem_shift   = {rem_ff, div_ff[TIME_W-1]};
   assign res         = alu_rsp.result;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= swec_pkg::ST_IDLE;
         latest_ff <= '0;
         first_ff  <= '0;
         total_ff  <= '0;
         oldest_ff <= '0;
         in_use_ff <= '0;
      end else begin
         state_ff  <= state_in;
         latest_ff <= latest_in;
         first_ff  <= first_in;
         total_ff  <= total_in;
         oldest_ff <= oldest_in;
         in_use_ff <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      cnt_ff    <= cnt_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      drop_ff   <= drop_in;
      target_ff <= target_in;
      trim_ff   <= trim_in;
   end

   // bucket ring; slots are zeroed when appended, so no clearing is needed
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      latest_in = latest_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      first_in  = first_ff;
      total_in  = total_ff;
      oldest_in = oldest_ff;
      in_use_in = in_use_ff;
      drop_in   = drop_ff;
      target_in = target_ff;
      trim_in   = trim_ff;

      mem_we    = 1'b0;
      mem_waddr = newest_slot;
      mem_wdata = '0;
      rd_addr   = newest_slot;

      alu_req.op = swec_pkg::ALU_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;

      req_ready     = 1'b0;
      status.done   = 1'b0;
      status.total  = total_ff;

      case (state_ff)
         swec_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in = req_cmd;
               cnt_in = req_event_count;
               div_in = req_now;
               if (req_cmd == swec_pkg::CMD_RESET) begin
                  latest_in = '0;
                  first_in  = '0;
                  total_in  = '0;
                  oldest_in = '0;
                  in_use_in = '0;
                  state_in  = swec_pkg::ST_DONE;
               end else begin
                  state_in = swec_pkg::ST_CLAMP;
               end
            end
         end

         // time never goes backwards
         swec_pkg::ST_CLAMP: begin
            alu_req.op = swec_pkg::ALU_SUB;
            alu_req.a  = ALU_W'(div_ff);
            alu_req.b  = ALU_W'(latest_ff);
            if (alu_rsp.flag) begin
               div_in = latest_ff;
            end else begin
               latest_in = div_ff;
            end
            rem_in   = '0;
            step_in  = '0;
            state_in = swec_pkg::ST_DIV;
         end

         // restoring division, one quotient bit per cycle
         swec_pkg::ST_DIV: begin
            alu_req.op = swec_pkg::ALU_SUB;
            alu_req.a  = ALU_W'(rem_shift);
            alu_req.b  = ALU_W'(ticks_eff);
            if (alu_rsp.flag) begin
               rem_in = rem_shift[swec_pkg::TICKS_W-1:0];
               div_in = {div_ff[TIME_W-2:0], 1'b0};
            end else begin
               rem_in = res[swec_pkg::TICKS_W-1:0];
               div_in = {div_ff[TIME_W-2:0], 1'b1};
            end
            step_in = step_ff + swec_pkg::STEP_W'(1);
            if (step_ff == swec_pkg::DIV_LAST_STEP) begin
               state_in = swec_pkg::ST_START;
            end
         end

         // first tracked window and the bucket count it implies
         swec_pkg::ST_START: begin
            alu_req.op = swec_pkg::ALU_SUB;
            alu_req.a  = ALU_W'(div_ff);
            alu_req.b  = ALU_W'(wc_eff - CW'(1));
            if (alu_rsp.flag) begin
               div_in    = '0;
               target_in = div_ff[CW-1:0] + CW'(1);
            end else begin
               div_in    = res[TIME_W-1:0];
               target_in = wc_eff;
            end
            state_in = swec_pkg::ST_GAP;
         end

         swec_pkg::ST_GAP: begin
            alu_req.op = swec_pkg::ALU_SUB;
            alu_req.a  = ALU_W'(div_ff);
            alu_req.b  = ALU_W'(first_ff);
            if (alu_rsp.flag || res == '0) begin
               drop_in = '0;
            end else if (res[ALU_W-1:CW] != '0 || res[CW-1:0] >= in_use_ff) begin
               drop_in = in_use_ff;
            end else begin
               drop_in = res[CW-1:0];
            end
            first_in = div_ff;
            trim_in  = 1'b0;
            if (drop_in != '0) begin
               state_in = swec_pkg::ST_DROP_RD;
            end else begin
               state_in = swec_pkg::ST_APPEND;
            end
         end

         swec_pkg::ST_DROP_RD: begin
            rd_addr  = oldest_ff;
            state_in = swec_pkg::ST_DROP;
         end

         // retire one bucket per cycle, read of the next one overlapped
         swec_pkg::ST_DROP: begin
            rd_addr    = oldest_inc;
            alu_req.op = swec_pkg::ALU_SUB;
            alu_req.a  = ALU_W'(total_ff);
            alu_req.b  = ALU_W'(rd_data_ff);
            total_in   = alu_rsp.flag ? '0 : res[CNT_W-1:0];
            oldest_in  = oldest_inc;
            in_use_in  = in_use_ff - CW'(1);
            drop_in    = drop_ff - CW'(1);
            if (drop_ff == CW'(1)) begin
               state_in = trim_ff ? swec_pkg::ST_TRIM : swec_pkg::ST_APPEND;
            end
         end

         swec_pkg::ST_APPEND: begin
            if (in_use_ff < target_ff) begin
               mem_we    = 1'b1;
               mem_waddr = slot_add(oldest_ff, in_use_ff);
               mem_wdata = '0;
               in_use_in = in_use_ff + CW'(1);
            end else begin
               state_in = swec_pkg::ST_TRIM;
            end
         end

         // drops buckets only after the window count was lowered, else goes on to record or done
         swec_pkg::ST_TRIM: begin
            if (in_use_ff > wc_eff) begin
               drop_in  = in_use_ff - wc_eff;
               trim_in  = 1'b1;
               state_in = swec_pkg::ST_DROP_RD;
            end else if (cmd_ff == swec_pkg::CMD_RECORD && in_use_ff != '0) begin
               state_in = swec_pkg::ST_REC_RD;
            end else begin
               state_in = swec_pkg::ST_DONE;
            end
         end

         swec_pkg::ST_REC_RD: begin
            state_in = swec_pkg::ST_REC_BKT;
         end

         swec_pkg::ST_REC_BKT: begin
            alu_req.op = swec_pkg::ALU_ADD;
            alu_req.a  = ALU_W'(rd_data_ff);
            alu_req.b  = ALU_W'(cnt_ff);
            mem_we     = 1'b1;
            mem_waddr  = newest_slot;
            mem_wdata  = res[CNT_W] ? swec_pkg::CNT_MAX : res[CNT_W-1:0];
            state_in   = swec_pkg::ST_REC_TOT;
         end

         swec_pkg::ST_REC_TOT: begin
            alu_req.op = swec_pkg::ALU_ADD;
            alu_req.a  = ALU_W'(total_ff);
            alu_req.b  = ALU_W'(cnt_ff);
            total_in   = res[CNT_W] ? swec_pkg::CNT_MAX : res[CNT_W-1:0];
            state_in   = swec_pkg::ST_DONE;
         end

         swec_pkg::ST_DONE: begin
            status.done = 1'b1;
            if (load_ok) begin
               state_in = swec_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = swec_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/sliding_window_event_counter.sv
// ----------------------------------------------------------------------------
// sliding_window_event_counter
// Bucketed sliding window event counter with a stream in and a stream out.
// ----------------------------------------------------------------------------
// Usage:
// - req_ channel: one item per command. tuser carries the command (record,
//   refresh, reset state), tdata the event count and the timestamp.
// - rsp_ channel: one item per request, the windowed total of events.
// - csr_ port: window_count (index 0) and window_ticks (index 1), written
//   while no item is in flight.
// - Work per item: a reset-state item goes straight to the result; a refresh
//   or record item clamps its timestamp, divides it by window_ticks with a
//   restoring division on the shared adder, retires expired buckets and
//   appends new ones; a record item then adds its event count to the
//   newest bucket and to the total. The division of the timestamp is the
//   longest part of that work.
// - One item is worked on at a time; req_tready is high only while idle.
// - The result sits in an output register, so a new item is taken while the
//   previous result waits; a stalled receiver holds the block only when the
//   next result is ready to be loaded.
// - Reset clears all window state, restores the register defaults
//   (16 windows of 10000000 ticks) and drops any pending result.
// ----------------------------------------------------------------------------
module sliding_window_event_counter #(
   parameter int MAX_WINDOWS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [95:0]                          req_tdata,  // event_count, now, zero pad
   input  logic [swec_pkg::CMD_W-1:0]           req_tuser,  // cmd
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swec_pkg::CNT_W-1:0]           rsp_tdata,  // total_count
   input  logic                                 csr_we,
   input  logic [swec_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [swec_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   swec_pkg::cfg_type     cfg_ff;
   swec_pkg::status_type  status;
   swec_pkg::alu_req_type alu_req;
   swec_pkg::alu_rsp_type alu_rsp;

   logic                        rsp_valid_ff;
   logic [swec_pkg::CNT_W-1:0]  rsp_data_ff;
   logic                        load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_count <= swec_pkg::WINDOW_COUNT_RST;
         cfg_ff.window_ticks <= swec_pkg::WINDOW_TICKS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            swec_pkg::CSR_WINDOW_COUNT: begin
               cfg_ff.window_count <= csr_wdata[swec_pkg::WCNT_W-1:0];
            end
            swec_pkg::CSR_WINDOW_TICKS: begin
               cfg_ff.window_ticks <= csr_wdata[swec_pkg::TICKS_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   assign load_ok = !rsp_valid_ff || rsp_tready;

   swec_seq #(
      .MAX_WINDOWS (MAX_WINDOWS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_tvalid),
      .req_cmd         (req_tuser),
      .req_event_count (req_tdata[31:0]),
      .req_now         (req_tdata[94:32]),
      .req_ready       (req_tready),
      .load_ok         (load_ok),
      .status          (status),
      .alu_req         (alu_req),
      .alu_rsp         (alu_rsp)
   );

   swec_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done && load_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done && load_ok) begin
         rsp_data_ff <= status.total;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/swec_chk.sv
// ----------------------------------------------------------------------------
// swec_chk
// Port-level checks of the sliding window event counter, bound to the top.
// ----------------------------------------------------------------------------
module swec_chk (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [swec_pkg::CNT_W-1:0]           rsp_tdata
);

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("swec: request accepted while an item is in flight");

   // a result is loaded only from the done step, never while idle
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("swec: result appeared without a finished item");

   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("swec: not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("swec: stalled result changed");

endmodule

bind sliding_window_event_counter swec_chk u_swec_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
